// File: hw/rtl/mbcu_pkg.sv
// ----------------------------------------------------------------------------
// mbcu_pkg
// Shared constants and register codes of the Maxwell-Bloch cell update.
// ----------------------------------------------------------------------------
package mbcu_pkg;

	localparam int FRAC_BITS        = 24;
	localparam int NUM_REGS         = 8;
	localparam int REG_IDX_W        = 3;
	localparam int FIELD_W          = 32;
	localparam int PC_PASSES_DEF    = 4;
	localparam int DATA_WIDTH_DEF   = 32;
	localparam int CELL_STAGES      = 5;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DT_DIPOLE    = 3'd0,
		REG_DT_RELAX     = 3'd1,
		REG_EQUI_INV     = 3'd2,
		REG_DT_TRANS     = 3'd3,
		REG_DT_DEPHASE   = 3'd4,
		REG_CONDUCTION   = 3'd5,
		REG_POLARIZATION = 3'd6,
		REG_CURL         = 3'd7
	} reg_idx_t;

endpackage

// File: hw/rtl/mbcu_cell.sv
// ----------------------------------------------------------------------------
// mbcu_cell
// One predictor-corrector pass as a five-stage pipeline.
// ----------------------------------------------------------------------------
module mbcu_cell #(
	parameter int DATA_WIDTH = mbcu_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic signed [DATA_WIDTH-1:0] coef [mbcu_pkg::NUM_REGS],
	input  logic                         vin,
	input  logic signed [DATA_WIDTH-1:0] inv0_i,
	input  logic signed [DATA_WIDTH-1:0] cr0_i,
	input  logic signed [DATA_WIDTH-1:0] ci0_i,
	input  logic signed [DATA_WIDTH-1:0] e0_i,
	input  logic signed [DATA_WIDTH-1:0] hdiff_i,
	input  logic signed [DATA_WIDTH-1:0] inv_i,
	input  logic signed [DATA_WIDTH-1:0] cr_i,
	input  logic signed [DATA_WIDTH-1:0] ci_i,
	input  logic signed [DATA_WIDTH-1:0] e_i,
	input  logic                         sat_i,
	output logic                         vout,
	output logic signed [DATA_WIDTH-1:0] inv0_o,
	output logic signed [DATA_WIDTH-1:0] cr0_o,
	output logic signed [DATA_WIDTH-1:0] ci0_o,
	output logic signed [DATA_WIDTH-1:0] e0_o,
	output logic signed [DATA_WIDTH-1:0] hdiff_o,
	output logic signed [DATA_WIDTH-1:0] inv_o,
	output logic signed [DATA_WIDTH-1:0] cr_o,
	output logic signed [DATA_WIDTH-1:0] ci_o,
	output logic signed [DATA_WIDTH-1:0] e_o,
	output logic                         sat_o
);
	import mbcu_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic [2*W:0] LIM  = (2*W+1)'(1) << (W-1);
	localparam logic [2*W:0] HALF = (2*W+1)'(1) << (FRAC_BITS-1);

	typedef logic signed [W-1:0] val_t;

	// results carry the clip flag in the top bit
	function automatic logic [W:0] f_add(val_t a, val_t b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1])
			return {1'b1, s[W] ? MINV : MAXV};
		return {1'b0, s[W-1:0]};
	endfunction

	function automatic logic [W:0] f_sub(val_t a, val_t b);
		logic signed [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1])
			return {1'b1, s[W] ? MINV : MAXV};
		return {1'b0, s[W-1:0]};
	endfunction

	function automatic val_t f_mid(val_t a, val_t b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		return s[W:1];
	endfunction

	// round to nearest, ties away from zero, then saturate
	function automatic logic [W:0] f_mul(val_t a, val_t b);
		logic signed [2*W-1:0] p;
		logic        [2*W:0]   m;
		logic        [2*W:0]   r;
		p = a * b;
		m = {1'b0, (p[2*W-1] ? -p : p)};
		r = (m + HALF) >> FRAC_BITS;
		if (p[2*W-1]) begin
			if (r > LIM)
				return {1'b1, MINV};
			if (r == LIM)
				return {1'b0, MINV};
			return {1'b0, -val_t'(r[W-1:0])};
		end
		if (r >= LIM)
			return {1'b1, MAXV};
		return {1'b0, r[W-1:0]};
	endfunction

	// stage 1: midpoints
	logic v_s1, sat_s1;
	val_t inv0_s1, cr0_s1, ci0_s1, e0_s1, hd_s1, invm_s1, crm_s1, cim_s1, em_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv0_s1 <= inv0_i;
			cr0_s1  <= cr0_i;
			ci0_s1  <= ci0_i;
			e0_s1   <= e0_i;
			hd_s1   <= hdiff_i;
			sat_s1  <= sat_i;
			invm_s1 <= f_mid(inv0_i, inv_i);
			crm_s1  <= f_mid(cr0_i, cr_i);
			cim_s1  <= f_mid(ci0_i, ci_i);
			em_s1   <= f_mid(e0_i, e_i);
		end
	end

	// stage 2: products with the registers, inversion minus equilibrium
	logic [W:0] rabi_c, wcr_c, wci_c, gci_c, gcr_c, ce_c, deq_c, curl_c;
	logic v_s2, sat_s2;
	val_t inv0_s2, cr0_s2, ci0_s2, e0_s2, hd_s2, invm_s2, cim_s2;
	val_t rabi_s2, wcr_s2, wci_s2, gci_s2, gcr_s2, ce_s2, deq_s2, curl_s2;

	always_comb begin
		rabi_c = f_mul(coef[REG_DT_DIPOLE], em_s1);
		wcr_c  = f_mul(coef[REG_DT_TRANS], crm_s1);
		wci_c  = f_mul(coef[REG_DT_TRANS], cim_s1);
		gci_c  = f_mul(coef[REG_DT_DEPHASE], cim_s1);
		gcr_c  = f_mul(coef[REG_DT_DEPHASE], crm_s1);
		ce_c   = f_mul(coef[REG_CONDUCTION], em_s1);
		deq_c  = f_sub(invm_s1, coef[REG_EQUI_INV]);
		curl_c = f_mul(coef[REG_CURL], hd_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv0_s2 <= inv0_s1;
			cr0_s2  <= cr0_s1;
			ci0_s2  <= ci0_s1;
			e0_s2   <= e0_s1;
			hd_s2   <= hd_s1;
			invm_s2 <= invm_s1;
			cim_s2  <= cim_s1;
			rabi_s2 <= rabi_c[W-1:0];
			wcr_s2  <= wcr_c[W-1:0];
			wci_s2  <= wci_c[W-1:0];
			gci_s2  <= gci_c[W-1:0];
			gcr_s2  <= gcr_c[W-1:0];
			ce_s2   <= ce_c[W-1:0];
			deq_s2  <= deq_c[W-1:0];
			curl_s2 <= curl_c[W-1:0];
			sat_s2  <= sat_s1 | rabi_c[W] | wcr_c[W] | wci_c[W] | gci_c[W] | gcr_c[W]
				| ce_c[W] | deq_c[W] | curl_c[W];
		end
	end

	// stage 3: second-level products and the coherence real part
	logic [W:0] rci_c, rinv_c, rel_c, pw_c, cra_c, cre_c, cia_c, ea_c;
	logic v_s3, sat_s3;
	val_t inv0_s3, cr0_s3, ci0_s3, e0_s3, hd_s3, curl_s3, gci_s3;
	val_t rci_s3, rinv_s3, rel_s3, pw_s3, cre_s3, cia_s3, ea_s3;

	always_comb begin
		rci_c  = f_mul(rabi_s2, cim_s2);
		rinv_c = f_mul(rabi_s2, invm_s2);
		rel_c  = f_mul(coef[REG_DT_RELAX], deq_s2);
		pw_c   = f_sub(wci_s2, gcr_s2);
		cra_c  = f_add(cr0_s2, wci_s2);
		cre_c  = f_sub(cra_c[W-1:0], gcr_s2);
		cia_c  = f_sub(ci0_s2, wcr_s2);
		ea_c   = f_sub(e0_s2, ce_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv0_s3 <= inv0_s2;
			cr0_s3  <= cr0_s2;
			ci0_s3  <= ci0_s2;
			e0_s3   <= e0_s2;
			hd_s3   <= hd_s2;
			curl_s3 <= curl_s2;
			gci_s3  <= gci_s2;
			rci_s3  <= rci_c[W-1:0];
			rinv_s3 <= rinv_c[W-1:0];
			rel_s3  <= rel_c[W-1:0];
			pw_s3   <= pw_c[W-1:0];
			cre_s3  <= cre_c[W-1:0];
			cia_s3  <= cia_c[W-1:0];
			ea_s3   <= ea_c[W-1:0];
			sat_s3  <= sat_s2 | rci_c[W] | rinv_c[W] | rel_c[W] | pw_c[W] | cra_c[W]
				| cre_c[W] | cia_c[W] | ea_c[W];
		end
	end

	// stage 4: inversion, coherence imaginary part, polarisation product
	logic [W:0] d2_c, d4_c, inva_c, inve_c, cib_c, cie_c, pol_c;
	logic v_s4, sat_s4;
	val_t inv0_s4, cr0_s4, ci0_s4, e0_s4, hd_s4, curl_s4;
	val_t inve_s4, cre_s4, cie_s4, ea_s4, pol_s4;

	always_comb begin
		d2_c   = f_add(rci_s3, rci_s3);
		d4_c   = f_add(d2_c[W-1:0], d2_c[W-1:0]);
		inva_c = f_sub(inv0_s3, d4_c[W-1:0]);
		inve_c = f_sub(inva_c[W-1:0], rel_s3);
		cib_c  = f_add(cia_s3, rinv_s3);
		cie_c  = f_sub(cib_c[W-1:0], gci_s3);
		pol_c  = f_mul(coef[REG_POLARIZATION], pw_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv0_s4 <= inv0_s3;
			cr0_s4  <= cr0_s3;
			ci0_s4  <= ci0_s3;
			e0_s4   <= e0_s3;
			hd_s4   <= hd_s3;
			curl_s4 <= curl_s3;
			cre_s4  <= cre_s3;
			ea_s4   <= ea_s3;
			inve_s4 <= inve_c[W-1:0];
			cie_s4  <= cie_c[W-1:0];
			pol_s4  <= pol_c[W-1:0];
			sat_s4  <= sat_s3 | d2_c[W] | d4_c[W] | inva_c[W] | inve_c[W] | cib_c[W]
				| cie_c[W] | pol_c[W];
		end
	end

	// stage 5: field update, hand on to the next cell
	logic [W:0] eb_c, ee_c;
	logic v_s5, sat_s5;

	always_comb begin
		eb_c = f_sub(ea_s4, pol_s4);
		ee_c = f_add(eb_c[W-1:0], curl_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv0_o  <= inv0_s4;
			cr0_o   <= cr0_s4;
			ci0_o   <= ci0_s4;
			e0_o    <= e0_s4;
			hdiff_o <= hd_s4;
			inv_o   <= inve_s4;
			cr_o    <= cre_s4;
			ci_o    <= cie_s4;
			e_o     <= ee_c[W-1:0];
			sat_s5  <= sat_s4 | eb_c[W] | ee_c[W];
		end
	end

	assign vout  = v_s5;
	assign sat_o = sat_s5;

endmodule

// File: hw/rtl/maxwell_bloch_cell_update.sv
// ----------------------------------------------------------------------------
// maxwell_bloch_cell_update
// Two-level Maxwell-Bloch grid-cell update, chain of predictor-corrector cells.
// ----------------------------------------------------------------------------
// Pipeline from input word to output word: an entry stage, five stages per pass
//   cell and an output register.
// Throughput: one word per cycle; every pass cell owns its own multipliers.
// The whole chain advances together; it holds only while a finished word waits
//   in the output register and another arrives behind it.
// Reset: arst_n clears all valid bits and the eight registers to zero.
module maxwell_bloch_cell_update #(
	parameter int PC_PASSES  = mbcu_pkg::PC_PASSES_DEF,
	parameter int DATA_WIDTH = mbcu_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [mbcu_pkg::REG_IDX_W-1:0]     cfg_addr,
	input  logic [mbcu_pkg::FIELD_W-1:0]       cfg_wdata,
	// input words
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// inversion_in, coh_real_in, coh_imag_in, efield_in, hfield_here,
	// hfield_next, 32 bits each from bit 0 up
	input  logic [6*mbcu_pkg::FIELD_W-1:0]     s_tdata,
	// result words
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// inversion_out, coh_real_out, coh_imag_out, efield_out from bit 0 up
	output logic [4*mbcu_pkg::FIELD_W-1:0]     m_tdata,
	// saturated
	output logic                               m_tuser
);
	import mbcu_pkg::*;

	localparam int W = DATA_WIDTH;
	typedef logic signed [W-1:0] val_t;
	localparam val_t MAXV = {1'b0, {(W-1){1'b1}}};
	localparam val_t MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [FIELD_W-1:0] F_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam logic signed [FIELD_W-1:0] F_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
	localparam int XW = (W > FIELD_W) ? W : FIELD_W;

	// bring a 32-bit field into the datapath width, flag in the top bit
	function automatic logic [W:0] to_dp(logic signed [FIELD_W-1:0] x);
		logic signed [XW-1:0] xe;
		xe = XW'(x);
		if (xe > XW'(MAXV))
			return {1'b1, MAXV};
		if (xe < XW'(MINV))
			return {1'b1, MINV};
		return {1'b0, xe[W-1:0]};
	endfunction

	// bring a datapath value back to the 32-bit field range
	function automatic logic [FIELD_W:0] to_field(val_t x);
		logic signed [XW-1:0] xe;
		xe = XW'(x);
		if (xe > XW'(F_MAX))
			return {1'b1, F_MAX};
		if (xe < XW'(F_MIN))
			return {1'b1, F_MIN};
		return {1'b0, xe[FIELD_W-1:0]};
	endfunction

	// ---- registers: stored at datapath width, with a note of any clip ----
	val_t              coef_q [NUM_REGS];
	logic [NUM_REGS-1:0] regclip_q;
	logic [W:0]        cfg_fit;

	assign cfg_fit = to_dp(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				coef_q[i] <= '0;
			regclip_q <= '0;
		end else if (cfg_we) begin
			coef_q[cfg_addr]    <= cfg_fit[W-1:0];
			regclip_q[cfg_addr] <= cfg_fit[W];
		end
	end

	// ---- chain control: all stalls on a blocked output with a word behind it ----
	logic en;
	logic v0_q;
	logic last_v;

	assign en       = !(m_tvalid && !m_tready && last_v);
	assign s_tready = en;

	// ---- entry stage: clip the fields, form the magnetic field difference ----
	logic [W:0] f_inv, f_cr, f_ci, f_e, f_hh, f_hn;
	logic signed [W:0] hd_sum;
	logic [W:0] hd_c;
	val_t inv0_q, cr0_q, ci0_q, e0_q, hd_q;
	logic sat0_q;

	always_comb begin
		f_inv  = to_dp(s_tdata[0*FIELD_W +: FIELD_W]);
		f_cr   = to_dp(s_tdata[1*FIELD_W +: FIELD_W]);
		f_ci   = to_dp(s_tdata[2*FIELD_W +: FIELD_W]);
		f_e    = to_dp(s_tdata[3*FIELD_W +: FIELD_W]);
		f_hh   = to_dp(s_tdata[4*FIELD_W +: FIELD_W]);
		f_hn   = to_dp(s_tdata[5*FIELD_W +: FIELD_W]);
		hd_sum = {f_hn[W-1], f_hn[W-1:0]} - {f_hh[W-1], f_hh[W-1:0]};
		if (hd_sum[W] != hd_sum[W-1])
			hd_c = {1'b1, hd_sum[W] ? MINV : MAXV};
		else
			hd_c = {1'b0, hd_sum[W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
		end else if (en) begin
			v0_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv0_q <= f_inv[W-1:0];
			cr0_q  <= f_cr[W-1:0];
			ci0_q  <= f_ci[W-1:0];
			e0_q   <= f_e[W-1:0];
			hd_q   <= hd_c[W-1:0];
			// register clips count against every word
			sat0_q <= (|regclip_q) | f_inv[W] | f_cr[W] | f_ci[W] | f_e[W] | f_hh[W]
				| f_hn[W] | hd_c[W];
		end
	end

	// ---- pass cells: estimates start at the old values ----
	logic v_c   [PC_PASSES+1];
	logic sat_c [PC_PASSES+1];
	val_t inv0_c [PC_PASSES+1];
	val_t cr0_c  [PC_PASSES+1];
	val_t ci0_c  [PC_PASSES+1];
	val_t e0_c   [PC_PASSES+1];
	val_t hd_c2  [PC_PASSES+1];
	val_t inv_c  [PC_PASSES+1];
	val_t cr_c   [PC_PASSES+1];
	val_t ci_c   [PC_PASSES+1];
	val_t e_c    [PC_PASSES+1];

	assign v_c[0]    = v0_q;
	assign sat_c[0]  = sat0_q;
	assign inv0_c[0] = inv0_q;
	assign cr0_c[0]  = cr0_q;
	assign ci0_c[0]  = ci0_q;
	assign e0_c[0]   = e0_q;
	assign hd_c2[0]  = hd_q;
	assign inv_c[0]  = inv0_q;
	assign cr_c[0]   = cr0_q;
	assign ci_c[0]   = ci0_q;
	assign e_c[0]    = e0_q;

	for (genvar p = 0; p < PC_PASSES; p++) begin : g_pass
		mbcu_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.coef   (coef_q),
			.vin    (v_c[p]),
			.inv0_i (inv0_c[p]),
			.cr0_i  (cr0_c[p]),
			.ci0_i  (ci0_c[p]),
			.e0_i   (e0_c[p]),
			.hdiff_i(hd_c2[p]),
			.inv_i  (inv_c[p]),
			.cr_i   (cr_c[p]),
			.ci_i   (ci_c[p]),
			.e_i    (e_c[p]),
			.sat_i  (sat_c[p]),
			.vout   (v_c[p+1]),
			.inv0_o (inv0_c[p+1]),
			.cr0_o  (cr0_c[p+1]),
			.ci0_o  (ci0_c[p+1]),
			.e0_o   (e0_c[p+1]),
			.hdiff_o(hd_c2[p+1]),
			.inv_o  (inv_c[p+1]),
			.cr_o   (cr_c[p+1]),
			.ci_o   (ci_c[p+1]),
			.e_o    (e_c[p+1]),
			.sat_o  (sat_c[p+1])
		);
	end

	assign last_v = v_c[PC_PASSES];

	// ---- output register: narrow to the field range ----
	logic [FIELD_W:0] o_inv, o_cr, o_ci, o_e;
	logic             load;

	assign o_inv = to_field(inv_c[PC_PASSES]);
	assign o_cr  = to_field(cr_c[PC_PASSES]);
	assign o_ci  = to_field(ci_c[PC_PASSES]);
	assign o_e   = to_field(e_c[PC_PASSES]);
	assign load  = en && last_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= {o_e[FIELD_W-1:0], o_ci[FIELD_W-1:0], o_cr[FIELD_W-1:0],
				o_inv[FIELD_W-1:0]};
			m_tuser <= sat_c[PC_PASSES] | o_inv[FIELD_W] | o_cr[FIELD_W] | o_ci[FIELD_W]
				| o_e[FIELD_W];
		end
	end

`ifndef SYNTHESIS
	// the chain only holds behind a blocked output word
	a_hold_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && last_v))
		else $error("input held without a blocked output word");

	// an accepted word enters the entry stage
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v0_q)
		else $error("accepted word lost at entry");

	// a word at the end of the chain reaches the output when the chain advances
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(last_v && en) |=> m_tvalid)
		else $error("finished word not loaded");
`endif

endmodule

// File: verif/tb_maxwell_bloch_cell_update.sv
// ----------------------------------------------------------------------------
// tb_maxwell_bloch_cell_update
// Streams grid cells through the Maxwell-Bloch cell update under several
// coefficient sets and idling patterns. Each result word is checked field by
// field against a fixed-point predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_maxwell_bloch_cell_update;
	timeunit 1ns;
	timeprecision 1ps;
	import mbcu_pkg::*;

	localparam longint Q_MAX      = 64'sd2147483647;
	localparam longint Q_MIN      = -64'sd2147483648;
	localparam int     DRAIN_WAIT = 40;    // beyond the pipeline latency
	localparam int     STUCK_MAX  = 5000;  // cycles with no word moving
	localparam int     HOLD_LEN   = 300;   // long receiver hold-off

	typedef struct {
		logic [FIELD_W-1:0] field [4];
		logic               sat;
	} cell_res_t;

	// Scoreboard: holds the coefficient copy, predicts each cell, keeps the
	// queue of pending results.
	class cell_scoreboard;
		longint    coeff [NUM_REGS];
		bit        clipped;
		cell_res_t pending_q [$];
		int        errors;

		function longint sat(longint v);
			if (v > Q_MAX) begin
				clipped = 1;
				return Q_MAX;
			end
			if (v < Q_MIN) begin
				clipped = 1;
				return Q_MIN;
			end
			return v;
		endfunction

		function longint add(longint a, longint b);
			return sat(a + b);
		endfunction

		function longint sub(longint a, longint b);
			return sat(a - b);
		endfunction

		function longint mid(longint a, longint b);
			return (a + b) >>> 1;
		endfunction

		// round to nearest, ties away from zero, on the magnitude
		function longint mul(longint a, longint b);
			longint p, mag, q;
			p   = a * b;
			mag = (p < 0) ? -p : p;
			q   = (mag + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
			if (p < 0) begin
				if (q == -Q_MIN)
					return Q_MIN;
				return sat(-q);
			end
			return sat(q);
		endfunction

		function longint times4(longint a);
			longint d;
			d = add(a, a);
			return add(d, d);
		endfunction

		function cell_res_t update_cell(logic [6*FIELD_W-1:0] w);
			longint in_v [6];
			longint inv_e, cr_e, ci_e, e_e, curl;
			longint inv_m, cr_m, ci_m, e_m, rabi, pw;
			cell_res_t r;
			clipped = 0;
			for (int k = 0; k < 6; k++)
				in_v[k] = longint'(signed'(w[FIELD_W*k +: FIELD_W]));
			curl  = mul(coeff[REG_CURL], sub(in_v[5], in_v[4]));
			inv_e = in_v[0];
			cr_e  = in_v[1];
			ci_e  = in_v[2];
			e_e   = in_v[3];
			for (int p = 0; p < PC_PASSES_DEF; p++) begin
				inv_m = mid(in_v[0], inv_e);
				cr_m  = mid(in_v[1], cr_e);
				ci_m  = mid(in_v[2], ci_e);
				e_m   = mid(in_v[3], e_e);
				rabi  = mul(coeff[REG_DT_DIPOLE], e_m);
				inv_e = sub(sub(in_v[0], times4(mul(rabi, ci_m))),
					mul(coeff[REG_DT_RELAX], sub(inv_m, coeff[REG_EQUI_INV])));
				ci_e  = sub(add(sub(in_v[2], mul(coeff[REG_DT_TRANS], cr_m)),
					mul(rabi, inv_m)), mul(coeff[REG_DT_DEPHASE], ci_m));
				cr_e  = sub(add(in_v[1], mul(coeff[REG_DT_TRANS], ci_m)),
					mul(coeff[REG_DT_DEPHASE], cr_m));
				pw    = sub(mul(coeff[REG_DT_TRANS], ci_m),
					mul(coeff[REG_DT_DEPHASE], cr_m));
				e_e   = add(sub(sub(in_v[3], mul(coeff[REG_CONDUCTION], e_m)),
					mul(coeff[REG_POLARIZATION], pw)), curl);
			end
			r.field[0] = inv_e[FIELD_W-1:0];
			r.field[1] = cr_e[FIELD_W-1:0];
			r.field[2] = ci_e[FIELD_W-1:0];
			r.field[3] = e_e[FIELD_W-1:0];
			r.sat      = clipped;
			return r;
		endfunction

		function void note_cell(logic [6*FIELD_W-1:0] w);
			pending_q.insert(pending_q.size(), update_cell(w));
		endfunction

		function void check_cell(logic [4*FIELD_W-1:0] d, logic u);
			cell_res_t e;
			string names [4] = '{"inversion_out", "coh_real_out",
				"coh_imag_out", "efield_out"};
			if (pending_q.size() == 0) begin
				$error("result word with nothing pending");
				errors++;
				return;
			end
			e = pending_q.pop_front();
			for (int k = 0; k < 4; k++)
				if (d[FIELD_W*k +: FIELD_W] !== e.field[k]) begin
					$error("%s: expected %h, got %h", names[k], e.field[k],
						d[FIELD_W*k +: FIELD_W]);
					errors++;
				end
			if (u !== e.sat) begin
				$error("saturated: expected %b, got %b", e.sat, u);
				errors++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [REG_IDX_W-1:0]       cfg_addr;
	logic [FIELD_W-1:0]         cfg_wdata;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [6*FIELD_W-1:0]       s_tdata;   // inversion, coh_real, coh_imag, efield, h_here, h_next
	logic                       m_tvalid;
	logic                       m_tready;
	logic [4*FIELD_W-1:0]       m_tdata;   // inversion, coh_real, coh_imag, efield
	logic                       m_tuser;   // saturated

	cell_scoreboard sb = new();
	int idle_mode;     // 0 none, 1 sender, 2 receiver, 3 both lightly
	bit hold_req;
	int hold_left;
	int stuck_cnt;

	maxwell_bloch_cell_update u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver: honour a long hold-off when asked, otherwise stall at random
	// according to the idling phase.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (idle_mode == 2) begin
			m_tready <= ($urandom_range(0, 99) >= 74);
		end else if (idle_mode == 3) begin
			m_tready <= ($urandom_range(0, 99) >= 16);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitors: note accepted input words, check accepted result words.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_cell(s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check_cell(m_tdata, m_tuser);
	end

	// Watchdog: end the run if no word moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck_cnt <= 0;
		else
			stuck_cnt <= stuck_cnt + 1;
		if (stuck_cnt >= STUCK_MAX) begin
			$display("tb: failure");
			$finish;
		end
	end

	function logic [FIELD_W-1:0] rand_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return $urandom;
		if (sel == 1)
			case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				3: return 32'hffff_ffff;
				default: return 32'h0000_0001;
			endcase
		// mostly within +-4.0
		return $urandom_range(0, 1 << 27) - (1 << 26);
	endfunction

	function logic [FIELD_W-1:0] rand_coeff();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		// within +-0.25
		return $urandom_range(0, 1 << 23) - (1 << 22);
	endfunction

	// Drive one register write; the enable stays up for a following write.
	task automatic write_reg(reg_idx_t idx, logic [FIELD_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		sb.coeff[idx] = longint'(signed'(val));
		@(posedge clk);
	endtask

	// Drop the write enable after a run of register writes.
	task automatic end_writes();
		cfg_we <= 1'b0;
	endtask

	// Offer one word, idling first as the phase asks, and hold it until taken.
	task automatic send_cell(logic [6*FIELD_W-1:0] w);
		int pct;
		pct = (idle_mode == 1) ? 74 : (idle_mode == 3) ? 16 : 0;
		while ($urandom_range(0, 99) < pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic send_fields(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
		logic [FIELD_W-1:0] c, logic [FIELD_W-1:0] d,
		logic [FIELD_W-1:0] e, logic [FIELD_W-1:0] f);
		send_cell({f, e, d, c, b, a});
	endtask

	// Drop valid and wait until every pending result has arrived and the
	// pipeline has drained.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		logic [6*FIELD_W-1:0] w;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		idle_mode = 0;
		hold_req  = 1'b0;
		hold_left = 0;
		stuck_cnt = 0;
		sb.errors = 0;
		for (int k = 0; k < NUM_REGS; k++)
			sb.coeff[k] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero coefficients after reset pass the state through.
		send_fields(32'h0100_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'hffff_ffff, 32'h0000_0001, 32'h0000_0003);
		drain();

		// Directed under a typical coefficient set.
		write_reg(REG_DT_DIPOLE,    32'h0008_0000);
		write_reg(REG_DT_RELAX,     32'h0002_0000);
		write_reg(REG_EQUI_INV,     32'hff00_0000);
		write_reg(REG_DT_TRANS,     32'h0010_0000);
		write_reg(REG_DT_DEPHASE,   32'h0001_0000);
		write_reg(REG_CONDUCTION,   32'h0000_8000);
		write_reg(REG_POLARIZATION, 32'hfff0_0000);
		write_reg(REG_CURL,         32'h0040_0000);
		end_writes();
		send_fields('0, '0, '0, '0, '0, '0);
		send_fields({FIELD_W{1'b1}}, {FIELD_W{1'b1}}, {FIELD_W{1'b1}},
			{FIELD_W{1'b1}}, {FIELD_W{1'b1}}, {FIELD_W{1'b1}});
		send_fields(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		// odd values exercise the round-down of the midpoint
		send_fields(32'h0000_0003, 32'hffff_fffd, 32'h0000_0001,
			32'hffff_ffff, 32'h0000_0005, 32'hffff_fffb);
		// h difference that saturates before the curl product
		send_fields(32'h0100_0000, 32'h0080_0000, 32'hff80_0000,
			32'h0200_0000, 32'h8000_0000, 32'h7fff_ffff);
		// rounding ties: products landing exactly on half an LSB
		send_fields(32'h0000_0080, 32'hffff_ff80, 32'h0080_0000,
			32'hff80_0000, 32'h0000_0000, 32'h0000_0001);
		send_fields(32'h0400_0000, 32'hfc00_0000, 32'h0300_0000,
			32'h0500_0000, 32'h0100_0000, 32'hff00_0000);
		drain();

		// Extreme coefficients: large positive, then large negative.
		for (int k = 0; k < NUM_REGS; k++)
			write_reg(reg_idx_t'(k), 32'h7fff_ffff);
		end_writes();
		send_fields(32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
			32'h0100_0000, '0, 32'h0000_0001);
		send_fields(32'hff00_0000, 32'h0000_0000, 32'h0100_0000,
			32'hff00_0000, 32'h0000_0001, '0);
		drain();
		for (int k = 0; k < NUM_REGS; k++)
			write_reg(reg_idx_t'(k), 32'h8000_0000);
		end_writes();
		send_fields(32'h0100_0000, 32'hff00_0000, 32'h0100_0000,
			32'h0100_0000, '0, 32'h0000_0001);
		send_fields(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		drain();

		// Random phases: fresh coefficients, cycle through the idling modes.
		for (int ph = 0; ph < 8; ph++) begin
			for (int k = 0; k < NUM_REGS; k++)
				write_reg(reg_idx_t'(k), rand_coeff());
			end_writes();
			idle_mode = ph % 4;
			for (int n = 0; n < 150; n++) begin
				// a stretch without idling inside every phase
				if (n == 100)
					idle_mode = 0;
				if (ph == 0 && n == 20)
					hold_req = 1'b1;
				if (ph == 4 && n == 60) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (sb.pending_q.size() != 0)
						@(posedge clk);
				end
				for (int k = 0; k < 6; k++)
					w[FIELD_W*k +: FIELD_W] = rand_value();
				send_cell(w);
			end
			drain();
		end

		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/mbcu_pkg.sv
hw/rtl/mbcu_cell.sv
hw/rtl/maxwell_bloch_cell_update.sv
verif/tb_maxwell_bloch_cell_update.sv
